// ===== src/jsu_pkg.sv =====
// Shared types, codes and helper functions of the JSON string unescaper.
package jsu_pkg;

  localparam int unsigned MaxItems = 3;

  typedef enum logic [2:0] {
    PH_PLAIN = 3'd0,
    PH_ESC   = 3'd1,
    PH_HEX0  = 3'd2,
    PH_HEX1  = 3'd3,
    PH_HEX2  = 3'd4,
    PH_HEX3  = 3'd5
  } phase_e;

  typedef enum logic [2:0] {
    ST_DATA   = 3'd0,
    ST_CLOSED = 3'd1,
    ST_UNTERM = 3'd2,
    ST_BADESC = 3'd3,
    ST_BADHEX = 3'd4
  } status_e;

  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChNul = 8'h00;
  localparam logic [7:0] ChLowerU = 8'h75;

  // Result items caused by one input item; bytes[0] goes out first.
  typedef struct packed {
    logic [1:0]                    cnt;
    status_e                       status;
    logic [MaxItems-1:0][7:0]      bytes;
  } jsu_grp_t;

  // Bit 4 set means the byte is not a hex digit.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) v = {1'b0, 4'(c - 8'h30)};
    else if (c >= 8'h41 && c <= 8'h46) v = {1'b0, 4'(c - 8'h37)};
    else if (c >= 8'h61 && c <= 8'h66) v = {1'b0, 4'(c - 8'h57)};
    return v;
  endfunction

endpackage

// ===== src/jsu_decode.sv =====
// Escape phase tracking and decode of one byte into its group of result items.
module jsu_decode (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic [7:0]       byte_i,
  output jsu_pkg::jsu_grp_t grp_o
);
  import jsu_pkg::*;

  phase_e      phase_q, phase_d;
  logic [11:0] acc_q, acc_d;
  logic [4:0]  hv;
  logic [15:0] cp;

  assign hv = hex_value(byte_i);
  assign cp = {acc_q, hv[3:0]};

  always_comb begin
    grp_o   = '{cnt: 2'd0, status: ST_DATA, bytes: '0};
    phase_d = phase_q;
    acc_d   = acc_q;
    unique case (phase_q)
      PH_ESC: begin
        phase_d    = PH_PLAIN;
        grp_o.cnt  = 2'd1;
        case (byte_i)
          ChQuote:  grp_o.bytes[0] = ChQuote;
          ChBslash: grp_o.bytes[0] = ChBslash;
          ChSlash:  grp_o.bytes[0] = ChSlash;
          8'h62:    grp_o.bytes[0] = 8'h08;
          8'h66:    grp_o.bytes[0] = 8'h0C;
          8'h6E:    grp_o.bytes[0] = 8'h0A;
          8'h72:    grp_o.bytes[0] = 8'h0D;
          8'h74:    grp_o.bytes[0] = 8'h09;
          ChLowerU: begin
            phase_d   = PH_HEX0;
            acc_d     = '0;
            grp_o.cnt = 2'd0;
          end
          default: begin
            acc_d        = '0;
            grp_o.status = ST_BADESC;
          end
        endcase
      end
      PH_HEX0, PH_HEX1, PH_HEX2: begin
        if (hv[4]) begin
          phase_d      = PH_PLAIN;
          acc_d        = '0;
          grp_o.cnt    = 2'd1;
          grp_o.status = ST_BADHEX;
        end else begin
          phase_d = phase_e'(phase_q + 3'd1);
          acc_d   = {acc_q[7:0], hv[3:0]};
        end
      end
      PH_HEX3: begin
        phase_d = PH_PLAIN;
        acc_d   = '0;
        if (hv[4]) begin
          grp_o.cnt    = 2'd1;
          grp_o.status = ST_BADHEX;
        end else if (cp[15:7] == '0) begin
          grp_o.cnt      = 2'd1;
          grp_o.bytes[0] = {1'b0, cp[6:0]};
        end else if (cp[15:11] == '0) begin
          grp_o.cnt      = 2'd2;
          grp_o.bytes[0] = {3'b110, cp[10:6]};
          grp_o.bytes[1] = {2'b10, cp[5:0]};
        end else begin
          grp_o.cnt      = 2'd3;
          grp_o.bytes[0] = {4'b1110, cp[15:12]};
          grp_o.bytes[1] = {2'b10, cp[11:6]};
          grp_o.bytes[2] = {2'b10, cp[5:0]};
        end
      end
      default: begin
        // Plain content; the unused phase codes fall in here as well.
        phase_d   = PH_PLAIN;
        grp_o.cnt = 2'd1;
        if (byte_i == ChQuote) begin
          acc_d        = '0;
          grp_o.status = ST_CLOSED;
        end else if (byte_i == ChNul) begin
          acc_d        = '0;
          grp_o.status = ST_UNTERM;
        end else if (byte_i == ChBslash) begin
          phase_d   = PH_ESC;
          grp_o.cnt = 2'd0;
        end else begin
          grp_o.bytes[0] = byte_i;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_PLAIN;
      acc_q   <= '0;
    end else if (adv_i) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= PH_HEX3)
    else $error("escape phase left the defined codes");
`endif

endmodule

// ===== src/jsu_out_buf.sv =====
// Result register that hands out a group of up to three items one per cycle while stall_i is low.
module jsu_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  jsu_pkg::jsu_grp_t grp_i,
  output logic              free_o,
  output logic              valid_o,
  input  logic              stall_i,
  output logic [7:0]        out_byte_o,
  output logic [2:0]        status_o,
  output logic              last_o
);
  import jsu_pkg::*;

  jsu_grp_t   grp_q;
  logic       vld_q;
  logic [1:0] idx_q;

  assign valid_o    = vld_q;
  assign last_o     = (idx_q == grp_q.cnt - 2'd1);
  assign out_byte_o = grp_q.bytes[idx_q];
  assign status_o   = grp_q.status;
  // The buffer can take a new group when empty or when its final item leaves now.
  assign free_o     = !vld_q || (!stall_i && last_o);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= '0;
    end else if (load_i) begin
      vld_q <= 1'b1;
      idx_q <= '0;
    end else if (vld_q && !stall_i) begin
      if (last_o) begin
        vld_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      grp_q <= grp_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_idx_in_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q |-> (grp_q.cnt != 2'd0 && idx_q < grp_q.cnt))
    else $error("item index outside its group");
  a_status_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && grp_q.status != ST_DATA) |-> (grp_q.cnt == 2'd1 && out_byte_o == 8'h00))
    else $error("status item not alone or carries data");
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o)
    else $error("group loaded over items not yet taken");
`endif

endmodule

// ===== src/json_string_unescaper.sv =====
// Top level of the JSON string unescaper: input register, decoder and result buffer.
//
//   channel  direction  handshake         payload
//   input    in         valid_i/stall_o   text_byte_i
//   result   out        valid_o/stall_i   out_byte_o, status_o, last_o
//
// An accepted item is held in the input register and decoded into the result
// buffer, which registers the group of results before the first one shows.
// One item is taken per cycle while each gives at most one result and stall_i is
// low; a \u escape that yields two or three UTF-8 bytes holds the input while
// the result buffer hands them out. Reset returns the phase to plain content.
// A stall on the result side backs up through the buffer into stall_o.
module json_string_unescaper (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       stall_o,
  input  logic [7:0] text_byte_i,
  output logic       valid_o,
  input  logic       stall_i,
  output logic [7:0] out_byte_o,
  output logic [2:0] status_o,
  output logic       last_o
);
  import jsu_pkg::*;

  logic     in_vld_q;
  logic [7:0] byte_q;
  logic     in_adv;
  logic     buf_free;
  jsu_grp_t grp;

  // Items with no result move on even while the buffer is still busy.
  assign in_adv  = in_vld_q && (grp.cnt == 2'd0 || buf_free);
  assign stall_o = in_vld_q && !in_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (valid_i && !stall_o) begin
      in_vld_q <= 1'b1;
    end else if (in_adv) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && !stall_o) begin
      byte_q <= text_byte_i;
    end
  end

  jsu_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (in_adv),
    .byte_i (byte_q),
    .grp_o  (grp)
  );

  jsu_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (in_adv && grp.cnt != 2'd0),
    .grp_i      (grp),
    .free_o     (buf_free),
    .valid_o    (valid_o),
    .stall_i    (stall_i),
    .out_byte_o (out_byte_o),
    .status_o   (status_o),
    .last_o     (last_o)
  );

endmodule

// ===== tb/sv/json_string_unescaper_tb.sv =====
// Self-checking testbench for the JSON string unescaper: directed table, random strings, scoreboard.
module json_string_unescaper_tb;
  import jsu_pkg::*;

  localparam int HalfPeriod = 10;
  localparam int RandBytes = 190;
  localparam int DrainCycles = 8;
  localparam int WatchdogLimit = 2000;
  localparam int NumDirected = 26;

  typedef struct packed {
    logic [7:0] data;
    status_e    status;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [7:0] text;
    bit         typed;
    result_t    want;
  } dir_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       valid_i = 1'b0;
  logic       stall_o;
  logic [7:0] text_byte_i = 8'h00;
  logic       valid_o;
  logic       stall_i = 1'b0;
  logic [7:0] out_byte_o;
  logic [2:0] status_o;
  logic       last_o;

  // Rows whose result is obvious carry it; the rest go through the predictor.
  dir_row_t dir_rows [NumDirected] = '{
    '{8'h00, 1'b1, '{8'h00, ST_UNTERM, 1'b1}},
    '{8'h41, 1'b1, '{8'h41, ST_DATA, 1'b1}},
    '{8'hFF, 1'b1, '{8'hFF, ST_DATA, 1'b1}},
    '{8'h01, 1'b1, '{8'h01, ST_DATA, 1'b1}},
    '{8'h5C, 1'b0, '0},
    '{8'h6E, 1'b0, '0},
    '{8'h5C, 1'b0, '0},
    '{8'h22, 1'b0, '0},
    '{8'h5C, 1'b0, '0},
    '{8'h75, 1'b0, '0},
    '{8'h30, 1'b0, '0},
    '{8'h30, 1'b0, '0},
    '{8'h30, 1'b0, '0},
    '{8'h30, 1'b0, '0},
    '{8'h5C, 1'b0, '0},
    '{8'h75, 1'b0, '0},
    '{8'h46, 1'b0, '0},
    '{8'h66, 1'b0, '0},
    '{8'h66, 1'b0, '0},
    '{8'h66, 1'b0, '0},
    '{8'h5C, 1'b0, '0},
    '{8'h00, 1'b1, '{8'h00, ST_BADESC, 1'b1}},
    '{8'h5C, 1'b0, '0},
    '{8'h75, 1'b0, '0},
    '{8'h67, 1'b1, '{8'h00, ST_BADHEX, 1'b1}},
    '{8'h22, 1'b1, '{8'h00, ST_CLOSED, 1'b1}}
  };

  logic [7:0] esc_letters [8] = '{8'h22, 8'h5C, 8'h2F, 8'h62, 8'h66, 8'h6E, 8'h72, 8'h74};

  phase_e     cur_phase = PH_PLAIN;
  logic [11:0] hex_acc = '0;
  result_t    step_out [3];
  int         step_cnt;
  result_t    pending_chars [$];
  result_t    want_r;
  int         send_idle_pct = 35;
  int         stall_pct = 66;
  int         rand_bytes = 0;
  int         err_count = 0;
  int         quiet_cycles = 0;

  json_string_unescaper uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (valid_i),
    .stall_o     (stall_o),
    .text_byte_i (text_byte_i),
    .valid_o     (valid_o),
    .stall_i     (stall_i),
    .out_byte_o  (out_byte_o),
    .status_o    (status_o),
    .last_o      (last_o)
  );

  always #HalfPeriod clk_i = ~clk_i;

  always @(posedge clk_i) begin
    stall_i <= ($urandom_range(99) < stall_pct);
  end

  function automatic int hex_digit(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
    return -1;
  endfunction

  function automatic logic [7:0] nibble_ascii(input logic [3:0] nib);
    if (nib < 4'd10) return 8'h30 + 8'(nib);
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(nib) - 8'd10;
  endfunction

  function automatic void emit(input logic [7:0] data, input status_e st, input logic last);
    step_out[step_cnt] = '{data, st, last};
    step_cnt++;
  endfunction

  // Any status other than data ends the string and clears the escape state.
  function automatic void end_string(input status_e st);
    emit(8'h00, st, 1'b1);
    cur_phase = PH_PLAIN;
    hex_acc = '0;
  endfunction

  // Advances the unescaper state by one text byte and fills step_out.
  function automatic void unescape_step(input logic [7:0] c);
    int          d;
    logic [15:0] cp;
    step_cnt = 0;
    case (cur_phase)
      PH_ESC: begin
        cur_phase = PH_PLAIN;
        case (c)
          ChQuote, ChBslash, ChSlash: emit(c, ST_DATA, 1'b1);
          8'h62: emit(8'h08, ST_DATA, 1'b1);
          8'h66: emit(8'h0C, ST_DATA, 1'b1);
          8'h6E: emit(8'h0A, ST_DATA, 1'b1);
          8'h72: emit(8'h0D, ST_DATA, 1'b1);
          8'h74: emit(8'h09, ST_DATA, 1'b1);
          ChLowerU: begin
            cur_phase = PH_HEX0;
            hex_acc = '0;
          end
          default: end_string(ST_BADESC);
        endcase
      end
      PH_HEX0, PH_HEX1, PH_HEX2, PH_HEX3: begin
        d = hex_digit(c);
        if (d < 0) begin
          end_string(ST_BADHEX);
        end else if (cur_phase != PH_HEX3) begin
          hex_acc = {hex_acc[7:0], 4'(d)};
          cur_phase = phase_e'(cur_phase + 3'd1);
        end else begin
          cp = {hex_acc, 4'(d)};
          cur_phase = PH_PLAIN;
          hex_acc = '0;
          if (cp < 16'h0080) begin
            emit(cp[7:0], ST_DATA, 1'b1);
          end else if (cp < 16'h0800) begin
            emit(8'hC0 | 8'(cp[10:6]), ST_DATA, 1'b0);
            emit(8'h80 | 8'(cp[5:0]), ST_DATA, 1'b1);
          end else begin
            emit(8'hE0 | 8'(cp[15:12]), ST_DATA, 1'b0);
            emit(8'h80 | 8'(cp[11:6]), ST_DATA, 1'b0);
            emit(8'h80 | 8'(cp[5:0]), ST_DATA, 1'b1);
          end
        end
      end
      default: begin
        cur_phase = PH_PLAIN;
        if (c == ChQuote) end_string(ST_CLOSED);
        else if (c == ChNul) end_string(ST_UNTERM);
        else if (c == ChBslash) cur_phase = PH_ESC;
        else emit(c, ST_DATA, 1'b1);
      end
    endcase
  endfunction

  function automatic void push_step();
    for (int i = 0; i < step_cnt; i++) pending_chars.insert(pending_chars.size(), step_out[i]);
  endfunction

  // Presents one item and holds it until the block takes it.
  task automatic drive_byte(input logic [7:0] b);
    bit taken;
    while ($urandom_range(99) < send_idle_pct) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    valid_i <= 1'b1;
    text_byte_i <= b;
    do begin
      @(negedge clk_i);
      taken = !stall_o;
      @(posedge clk_i);
    end while (!taken);
  endtask

  task automatic send_text(input logic [7:0] b);
    unescape_step(b);
    push_step();
    drive_byte(b);
    rand_bytes++;
  endtask

  // One string: well-formed segments, then a close, an end of text or a broken escape.
  task automatic send_string();
    int          nseg;
    int          kind;
    logic [7:0]  b;
    logic [15:0] cp;
    nseg = $urandom_range(1, 8);
    for (int s = 0; s < nseg; s++) begin
      kind = $urandom_range(0, 9);
      if (kind < 5) begin
        do b = 8'($urandom_range(1, 255)); while (b == ChQuote || b == ChBslash);
        send_text(b);
      end else if (kind < 7) begin
        send_text(ChBslash);
        send_text(esc_letters[$urandom_range(0, 7)]);
      end else begin
        case ($urandom_range(0, 2))
          0: cp = 16'($urandom_range(0, 'h7F));
          1: cp = 16'($urandom_range('h80, 'h7FF));
          default: cp = 16'($urandom_range('h800, 'hFFFF));
        endcase
        send_text(ChBslash);
        send_text(ChLowerU);
        for (int i = 3; i >= 0; i--) send_text(nibble_ascii(cp[4*i +: 4]));
      end
    end
    kind = $urandom_range(0, 9);
    if (kind < 7) begin
      send_text(ChQuote);
    end else if (kind == 7) begin
      send_text(ChNul);
    end else if (kind == 8) begin
      send_text(ChBslash);
      if ($urandom_range(0, 3) == 0) b = ChNul;
      else begin
        do b = 8'($urandom_range(0, 255));
        while (b inside {8'h22, 8'h5C, 8'h2F, 8'h62, 8'h66, 8'h6E, 8'h72, 8'h74, 8'h75});
      end
      send_text(b);
    end else begin
      send_text(ChBslash);
      send_text(ChLowerU);
      for (int i = $urandom_range(0, 3); i > 0; i--) begin
        send_text(nibble_ascii(4'($urandom_range(0, 15))));
      end
      if ($urandom_range(0, 3) == 0) b = ChNul;
      else begin
        do b = 8'($urandom_range(0, 255)); while (hex_digit(b) >= 0);
      end
      send_text(b);
    end
  endtask

  // Outputs are sampled mid-cycle, where nothing driven at the clock edge can race.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if ((valid_i && !stall_o) || (valid_o && !stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("json_string_unescaper_tb: FAIL");
        $finish;
      end else if (valid_o && !stall_i) begin
        if (pending_chars.size() == 0) begin
          $error("result with nothing expected: out_byte %0h status %0d last %0b",
                 out_byte_o, status_o, last_o);
          err_count++;
        end else begin
          want_r = pending_chars.pop_front();
          if (out_byte_o !== want_r.data) begin
            $error("out_byte: expected %0h, got %0h", want_r.data, out_byte_o);
            err_count++;
          end
          if (status_o !== want_r.status) begin
            $error("status: expected %0d, got %0d", want_r.status, status_o);
            err_count++;
          end
          if (last_o !== want_r.last) begin
            $error("last: expected %0b, got %0b", want_r.last, last_o);
            err_count++;
          end
        end
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < NumDirected; r++) begin
      unescape_step(dir_rows[r].text);
      if (dir_rows[r].typed) pending_chars.insert(pending_chars.size(), dir_rows[r].want);
      else push_step();
      drive_byte(dir_rows[r].text);
    end

    while (rand_bytes < RandBytes) begin
      if (rand_bytes < RandBytes / 3) begin
        send_idle_pct = 35;
        stall_pct = 66;
      end else if (rand_bytes < 2 * RandBytes / 3) begin
        send_idle_pct = 66;
        stall_pct = 35;
      end else begin
        send_idle_pct = 0;
        stall_pct = 0;
      end
      // Now and then a burst of raw bytes, which may leave an escape half done.
      if ($urandom_range(0, 6) == 0) begin
        for (int i = $urandom_range(1, 6); i > 0; i--) send_text(8'($urandom_range(0, 255)));
      end else begin
        send_string();
      end
    end
    valid_i <= 1'b0;

    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (err_count == 0) $display("json_string_unescaper_tb: PASS");
    else $display("json_string_unescaper_tb: FAIL");
    $finish;
  end

endmodule
